FILE: rtl/utf8d_pkg.sv
// utf8d_pkg: shared types and constants for the UTF-8 stream decoder.
// Used by utf8d_step, utf8d_out_buf and utf8_stream_decoder.
package utf8d_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] CP_MAX_KEPT  = 21'h00FFFF;
  localparam logic [CP_W-1:0] CP_MAX_VALID = 21'h10FFFF;

  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_BAD_LEAD = 2'd1,
    KIND_RANGE    = 2'd2,
    KIND_END      = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [CP_W-1:0]  code_point;
    logic             kept;
  } result_t;

endpackage

FILE: rtl/utf8d_step.sv
// utf8d_step: per-byte decode logic with the sequence state registers.
// Depends on utf8d_pkg.
module utf8d_step
  import utf8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  logic [7:0]      in_byte,
  output logic            has_result,
  output result_t         result
);

  logic [1:0]      bytes_left;
  logic [1:0]      bytes_left_next;
  logic [CP_W-1:0] partial_point;
  logic [CP_W-1:0] partial_point_next;
  logic [CP_W-1:0] shifted;

  assign shifted = {partial_point[CP_W-7:0], in_byte[5:0]};

  always_comb begin
    bytes_left_next    = bytes_left;
    partial_point_next = partial_point;
    has_result         = 1'b0;
    result.kind        = KIND_CHAR;
    result.code_point  = '0;
    result.kept        = 1'b0;
    if (bytes_left != 2'd0) begin
      bytes_left_next    = bytes_left - 2'd1;
      partial_point_next = shifted;
      if (bytes_left == 2'd1) begin
        has_result         = 1'b1;
        partial_point_next = '0;
        result.code_point  = shifted;
        if (shifted > CP_MAX_VALID) begin
          result.kind = KIND_RANGE;
        end else begin
          result.kind = KIND_CHAR;
          result.kept = (shifted <= CP_MAX_KEPT);
        end
      end
    end else begin
      priority if (in_byte == 8'h00) begin
        has_result  = 1'b1;
        result.kind = KIND_END;
      end else if (in_byte[7] == 1'b0) begin
        has_result        = 1'b1;
        result.kind       = KIND_CHAR;
        result.code_point = {{(CP_W-8){1'b0}}, in_byte};
        result.kept       = 1'b1;
      end else if (in_byte[7:5] == 3'b110) begin
        bytes_left_next    = 2'd1;
        partial_point_next = {{(CP_W-5){1'b0}}, in_byte[4:0]};
      end else if (in_byte[7:4] == 4'b1110) begin
        bytes_left_next    = 2'd2;
        partial_point_next = {{(CP_W-4){1'b0}}, in_byte[3:0]};
      end else if (in_byte[7:3] == 5'b11110) begin
        bytes_left_next    = 2'd3;
        partial_point_next = {{(CP_W-3){1'b0}}, in_byte[2:0]};
      end else begin
        has_result         = 1'b1;
        result.kind        = KIND_BAD_LEAD;
        partial_point_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left    <= 2'd0;
      partial_point <= '0;
    end else if (fire) begin
      bytes_left    <= bytes_left_next;
      partial_point <= partial_point_next;
    end
  end

  a_kept_only_char: assert property (@(posedge clk) disable iff (rst)
    has_result && result.kept |-> result.kind == KIND_CHAR)
    else $error("kept set on a non-character result");

  a_range_above_max: assert property (@(posedge clk) disable iff (rst)
    has_result && result.kind == KIND_RANGE |-> result.code_point > CP_MAX_VALID)
    else $error("range error on an in-range code point");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    fire && bytes_left != 2'd0 |=> bytes_left == $past(bytes_left) - 2'd1)
    else $error("continuation did not advance the byte count");

  a_result_at_end: assert property (@(posedge clk) disable iff (rst)
    has_result && bytes_left != 2'd0 |-> bytes_left == 2'd1)
    else $error("result reported mid-sequence");

endmodule

FILE: rtl/utf8d_out_buf.sv
// utf8d_out_buf: two-entry result buffer that decouples output ready from the input side.
// Depends on utf8d_pkg.
module utf8d_out_buf
  import utf8d_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_valid,
  output logic    wr_ready,
  input  result_t wr_data,
  output logic    rd_valid,
  input  logic    rd_ready,
  output result_t rd_data
);

  result_t    entries [2];
  logic       head;
  logic       tail;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = entries[head];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        tail <= ~tail;
      end
      if (pop) begin
        head <= ~head;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer overflow");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> head == tail)
    else $error("buffer pointers disagree with count");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    rd_valid && !rd_ready && !$past(rst) |=> rd_valid && $stable(rd_data))
    else $error("stalled result changed");

endmodule

FILE: rtl/utf8_stream_decoder.sv
// utf8_stream_decoder: top level, input register, decode step and result buffer.
// Depends on utf8d_pkg, utf8d_step and utf8d_out_buf.
//
// Decodes a UTF-8 byte stream at one byte per clock while the output side takes
// results. Each request on the input channel carries one byte; a byte is
// registered, decoded and its result (if any) written to a two-entry output
// buffer. Lead and continuation bytes of multi-byte sequences produce no result
// until the last byte; a completed code point, an invalid lead, a code point
// above 0x10FFFF, or a NUL at a lead position produce one result.
module utf8_stream_decoder
  import utf8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      kind,
  output logic [CP_W-1:0] code_point,
  output logic [7:0]      out_char,
  output logic            kept
);

  logic    s1_valid;
  logic [7:0] s1_byte;
  logic    s1_move;
  logic    has_result;
  logic    buf_ready;
  result_t step_result;
  result_t buf_result;

  assign s1_move  = s1_valid && (!has_result || buf_ready);
  assign in_ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= in_byte;
    end
  end

  utf8d_step u_step (
    .clk        (clk),
    .rst        (rst),
    .fire       (s1_move),
    .in_byte    (s1_byte),
    .has_result (has_result),
    .result     (step_result)
  );

  utf8d_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (s1_valid && has_result),
    .wr_ready (buf_ready),
    .wr_data  (step_result),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_data  (buf_result)
  );

  assign kind       = buf_result.kind;
  assign code_point = buf_result.code_point;
  assign out_char   = buf_result.code_point[7:0];
  assign kept       = buf_result.kept;

  a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (rst)
    s1_valid && has_result && !buf_ready |-> !in_ready)
    else $error("request accepted while decode stage is blocked");

  a_stage_loaded: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted request lost from input register");

  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_byte))
    else $error("blocked byte changed in input register");

endmodule

FILE: test/utf8_decode_check.sv
`timescale 1ns / 1ps
// utf8_decode_check: watches the byte and result channels of utf8_stream_decoder,
// predicts each decoded result and compares it field by field. Depends on utf8d_pkg.
module utf8_decode_check
  import utf8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            out_valid,
  input  logic            out_ready,
  input  logic [1:0]      kind,
  input  logic [CP_W-1:0] code_point,
  input  logic [7:0]      out_char,
  input  logic            kept,
  output int              errors,
  output int              pending
);

  typedef struct {
    kind_t           kind;
    logic [CP_W-1:0] code_point;
    logic [7:0]      ch;
    logic            kept;
  } decoded_t;

  decoded_t        decoded_q[$];
  logic [1:0]      cont_left;
  logic [CP_W-1:0] partial_cp;

  initial begin
    errors = 0;
    pending = 0;
    cont_left = '0;
    partial_cp = '0;
  end

  function automatic decoded_t complete_point(input logic [CP_W-1:0] cp);
    decoded_t r;
    r.code_point = cp;
    r.ch = cp[7:0];
    if (cp > CP_MAX_VALID) begin
      r.kind = KIND_RANGE;
      r.kept = 1'b0;
    end else begin
      r.kind = KIND_CHAR;
      r.kept = (cp <= CP_MAX_KEPT);
    end
    return r;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    decoded_t r;
    r.kind = KIND_END;
    r.code_point = '0;
    r.ch = '0;
    r.kept = 1'b0;
    if (cont_left != 2'd0) begin
      partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        decoded_q.push_back(complete_point(partial_cp));
        partial_cp = '0;
      end
    end else if (b == 8'h00) begin
      decoded_q.push_back(r);
    end else if (!b[7]) begin
      decoded_q.push_back(complete_point({13'd0, b}));
    end else if (b[7:5] == 3'b110) begin
      partial_cp = {16'd0, b[4:0]};
      cont_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      partial_cp = {17'd0, b[3:0]};
      cont_left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      partial_cp = {18'd0, b[2:0]};
      cont_left = 2'd3;
    end else begin
      r.kind = KIND_BAD_LEAD;
      decoded_q.push_back(r);
      partial_cp = '0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t utf8_decode_check: %s", $time, msg);
    errors++;
  endtask

  task automatic match_result();
    decoded_t e;
    if (decoded_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: kind %0d cp %h", kind,
                                code_point));
    end else begin
      e = decoded_q.pop_front();
      if (kind !== e.kind)
        report_mismatch($sformatf("kind %0d, want %s", kind, e.kind.name()));
      if (code_point !== e.code_point)
        report_mismatch($sformatf("code_point %h, want %h", code_point, e.code_point));
      if (out_char !== e.ch)
        report_mismatch($sformatf("out_char %h, want %h", out_char, e.ch));
      if (kept !== e.kept)
        report_mismatch($sformatf("kept %b, want %b (cp %h)", kept, e.kept,
                                  e.code_point));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      decoded_q.delete();
      cont_left = '0;
      partial_cp = '0;
    end else begin
      if (out_valid && out_ready) match_result();
      if (in_valid && in_ready) decode_byte(in_byte);
    end
    pending = decoded_q.size();
  end

endmodule

FILE: test/tb_utf8_stream_decoder.sv
`timescale 1ns / 1ps
// tb_utf8_stream_decoder: drives UTF-8 byte requests into utf8_stream_decoder under
// varying idle and stall phases; utf8_decode_check predicts and compares results.
module tb_utf8_stream_decoder;
  import utf8d_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int PHASE_BYTES    = 240;

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_ready;
  logic [7:0]      in_byte;
  logic            out_valid;
  logic            out_ready;
  logic [1:0]      kind;
  logic [CP_W-1:0] code_point;
  logic [7:0]      out_char;
  logic            kept;

  int          err_count;
  int          pending;
  int          send_idle_pct;
  int          stall_pct;
  int unsigned bytes_sent;
  int unsigned idle_cycles;

  utf8_stream_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .code_point(code_point),
    .out_char  (out_char),
    .kept      (kept)
  );

  utf8_decode_check u_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .code_point(code_point),
    .out_char  (out_char),
    .kept      (kept),
    .errors    (err_count),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99, 0) >= stall_pct);
    end
  end

  initial idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_utf8_stream_decoder: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid = 1'b0;
      in_byte = 8'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte = b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // mostly well-formed sequences with random payload bits, some broken tails and noise
  task automatic send_unit();
    int unsigned pick;
    int unsigned n;
    logic        raw_tail;
    logic [7:0]  lead;
    pick = $urandom_range(99, 0);
    n = 0;
    raw_tail = 1'b0;
    if (pick < 20) begin
      lead = {1'b0, 7'($urandom)};
    end else if (pick < 38) begin
      lead = {3'b110, 5'($urandom)};
      n = 1;
    end else if (pick < 56) begin
      lead = {4'b1110, 4'($urandom)};
      n = 2;
    end else if (pick < 74) begin
      lead = {5'b11110, 3'($urandom)};
      n = 3;
    end else if (pick < 80) begin
      lead = 8'h00;
    end else if (pick < 90) begin
      lead = {2'b11, 6'($urandom)};
      n = $urandom_range(3, 0);
      raw_tail = 1'b1;
    end else begin
      lead = 8'($urandom);
    end
    send_byte(lead);
    repeat (n) send_byte(raw_tail ? 8'($urandom) : {2'b10, 6'($urandom)});
  endtask

  initial begin
    logic [7:0] directed[$];
    int         phase;
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'h00;
    send_idle_pct = 0;
    stall_pct = 0;
    bytes_sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // NUL, ASCII max, bad leads, 0xFFFF, 0x10000, 0x10FFFF, 0x110000,
    // overlong with NUL inside, surrogate with an unprefixed tail byte
    directed = '{8'h00, 8'h7F, 8'h80, 8'hF8, 8'hFF,
                 8'hEF, 8'hBF, 8'hBF,
                 8'hF0, 8'h90, 8'h80, 8'h80,
                 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                 8'hF4, 8'h90, 8'h80, 8'h80,
                 8'hC0, 8'h00,
                 8'hED, 8'hA0, 8'h41};
    foreach (directed[i]) send_byte(directed[i]);

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        1: begin
          send_idle_pct = 72;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 72;
        end
        3: begin
          send_idle_pct = 17;
          stall_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
      endcase
      while (bytes_sent < directed.size() + (phase + 1) * PHASE_BYTES) send_unit();
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_utf8_stream_decoder: done, clean");
    end else begin
      $display("tb_utf8_stream_decoder: done, errors");
    end
    $finish;
  end

endmodule

FILE: utf8_stream_decoder.f
rtl/utf8d_pkg.sv
rtl/utf8d_step.sv
rtl/utf8d_out_buf.sv
rtl/utf8_stream_decoder.sv
test/utf8_decode_check.sv
test/tb_utf8_stream_decoder.sv
